FILE: hw/rtl/ghp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared widths, constants and register codes of the Gaussian heat-map pixel
// unit.
// ----------------------------------------------------------------------------
package ghp_pkg;

  // field widths
  localparam int unsigned PixW      = 8;
  localparam int unsigned JointW    = 17;
  localparam int unsigned GridW     = 16;
  localparam int unsigned CoefW     = 20;
  localparam int unsigned HeatW     = 16;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 16;
  localparam int unsigned CfgAddrW  = 1;
  localparam int unsigned CfgDataW  = 20;

  // datapath widths
  localparam int unsigned DistW   = 24;
  localparam int unsigned SqW     = 2 * DistW;
  localparam int unsigned ArgW    = 29;
  localparam int unsigned ExpW    = 21;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ShW     = ExpW - FracW;
  localparam int unsigned TabW    = 17;

  // pixel index limit of the heat map
  localparam int unsigned GridMax = 256;

  // fixed-point constants
  localparam logic [JointW-1:0] JointOne  = 17'h10000;
  localparam logic [ArgW-1:0]   ArgMax    = 29'h1000_0000;
  localparam logic [16:0]       Log2eQ16  = 17'd94548;
  localparam logic [31:0]       Ln2Q32    = 32'd2977044472;
  localparam logic [HeatW-1:0]  HeatMax   = 16'hFFFF;

  // configuration reset values
  localparam logic [GridW-1:0] GridRecipRst = 16'd1024;
  localparam logic [CoefW-1:0] GaussCoefRst = 20'd51200;

  // register stages from input transfer to output register
  localparam int unsigned PipeDepth = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CfgGridRecip = 1'b0,
    CfgGaussCoef = 1'b1
  } cfg_reg_e;

endpackage

FILE: hw/rtl/ghp_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_dist
// Three-stage front end: pixel scaling and joint clamp, absolute axis
// distance, squared distance per axis.
// ----------------------------------------------------------------------------
module ghp_dist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ghp_pkg::PixW-1:0]       pixel_row_i,
  input  logic [ghp_pkg::PixW-1:0]       pixel_col_i,
  input  logic [ghp_pkg::JointW-1:0]     joint_x_i,
  input  logic [ghp_pkg::JointW-1:0]     joint_y_i,
  input  logic [ghp_pkg::GridW-1:0]      grid_recip_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ghp_pkg::SqW-1:0]        dx_sq_o,
  output logic [ghp_pkg::SqW-1:0]        dy_sq_o
);

  localparam int unsigned DistW = ghp_pkg::DistW;
  localparam int unsigned SqW   = ghp_pkg::SqW;

  function automatic logic [ghp_pkg::PixW-1:0] clamp_pix(input logic [ghp_pkg::PixW-1:0] p);
    logic [ghp_pkg::PixW-1:0] r;
    r = p;
    if (32'(p) > ghp_pkg::GridMax - 1) begin
      r = ghp_pkg::PixW'(ghp_pkg::GridMax - 1);
    end
    return r;
  endfunction

  function automatic logic [ghp_pkg::JointW-1:0] clamp_joint(
    input logic [ghp_pkg::JointW-1:0] j
  );
    return (j > ghp_pkg::JointOne) ? ghp_pkg::JointOne : j;
  endfunction

  function automatic logic [DistW-1:0] abs_diff(input logic [DistW-1:0] a,
                                                input logic [DistW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic [DistW-1:0]          px_d, py_d, px_q, py_q;
  logic [ghp_pkg::JointW-1:0] jx_d, jy_d, jx_q, jy_q;
  logic [DistW-1:0]          dx_d, dy_d, dx_q, dy_q;
  logic [SqW-1:0]            dx_sq_d, dy_sq_d, dx_sq_q, dy_sq_q;

  assign rdy[2]     = !vld_q[2] || out_ready_i;
  assign rdy[1]     = !vld_q[1] || rdy[2];
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign px_d = DistW'(clamp_pix(pixel_col_i)) * DistW'(grid_recip_i);
  assign py_d = DistW'(clamp_pix(pixel_row_i)) * DistW'(grid_recip_i);
  assign jx_d = clamp_joint(joint_x_i);
  assign jy_d = clamp_joint(joint_y_i);

  assign dx_d = abs_diff(px_q, DistW'(jx_q));
  assign dy_d = abs_diff(py_q, DistW'(jy_q));

  assign dx_sq_d = SqW'(dx_q) * SqW'(dx_q);
  assign dy_sq_d = SqW'(dy_q) * SqW'(dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      px_q <= px_d;
      py_q <= py_d;
      jx_q <= jx_d;
      jy_q <= jy_d;
    end
    if (rdy[1] && vld_q[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (rdy[2] && vld_q[1]) begin
      dx_sq_q <= dx_sq_d;
      dy_sq_q <= dy_sq_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign dx_sq_o     = dx_sq_q;
  assign dy_sq_o     = dy_sq_q;

endmodule

FILE: hw/rtl/ghp_arg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_arg
// Three-stage exponent path: distance sum with clamp, coefficient product
// with clamp at 16.0, scaling by log2(e) into a base-2 exponent.
// ----------------------------------------------------------------------------
module ghp_arg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ghp_pkg::SqW-1:0]      dx_sq_i,
  input  logic [ghp_pkg::SqW-1:0]      dy_sq_i,
  input  logic [ghp_pkg::CoefW-1:0]    gauss_coef_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ghp_pkg::ExpW-1:0]     exp2_arg_o
);

  localparam int unsigned SqW    = ghp_pkg::SqW;
  localparam int unsigned SumW   = SqW + 1;
  localparam int unsigned ArgW   = ghp_pkg::ArgW;
  localparam int unsigned ExpW   = ghp_pkg::ExpW;
  localparam int unsigned ProdW  = ArgW + ghp_pkg::CoefW;
  localparam int unsigned ScaleW = ArgW + 17;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic [SumW-1:0]   sum_sq;
  logic [SumW-17:0]  scaled;
  logic [ArgW-1:0]   dist_d, dist_q;
  logic [ProdW-1:0]  prod;
  logic [ArgW-1:0]   arg_d, arg_q;
  logic [ScaleW-1:0] scale_prod;
  logic [ExpW-1:0]   exp_d, exp_q;

  assign rdy[2]     = !vld_q[2] || out_ready_i;
  assign rdy[1]     = !vld_q[1] || rdy[2];
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  // saturating at 4096.0 here is exact: any nonzero coefficient saturates later
  assign sum_sq = SumW'(dx_sq_i) + SumW'(dy_sq_i);
  assign scaled = sum_sq[SumW-1:16];
  assign dist_d = (scaled > (SumW-16)'(ghp_pkg::ArgMax)) ? ghp_pkg::ArgMax : ArgW'(scaled);

  assign prod  = ProdW'(dist_q) * ProdW'(gauss_coef_i);
  assign arg_d = (prod > ProdW'(ghp_pkg::ArgMax)) ? ghp_pkg::ArgMax : ArgW'(prod);

  assign scale_prod = ScaleW'(arg_q) * ScaleW'(ghp_pkg::Log2eQ16);
  assign exp_d      = ExpW'(scale_prod >> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      dist_q <= dist_d;
    end
    if (rdy[1] && vld_q[0]) begin
      arg_q <= arg_d;
    end
    if (rdy[2] && vld_q[1]) begin
      exp_q <= exp_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign exp2_arg_o  = exp_q;

endmodule

FILE: hw/rtl/ghp_exp2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_exp2
// Two-stage power of two: fractional table lookup, then integer right shift
// and saturation into the output register.
// ----------------------------------------------------------------------------
module ghp_exp2 #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ghp_pkg::ExpW-1:0]     exp2_arg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ghp_pkg::HeatW-1:0]    heat_value_o
);

  localparam int unsigned IdxW  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned TabW  = ghp_pkg::TabW;
  localparam int unsigned ShW   = ghp_pkg::ShW;
  localparam int unsigned FracW = ghp_pkg::FracW;
  localparam int unsigned HeatW = ghp_pkg::HeatW;

  // 2^-(i/depth) in Q1.16 from a series of e^-x
  function automatic logic [TabW-1:0] exp2_entry(input int unsigned i);
    logic [95:0] x;
    logic [95:0] term;
    logic [95:0] sum;
    int unsigned k;
    x    = (96'(i) * 96'(ghp_pkg::Ln2Q32)) / 96'(EXP_TABLE_DEPTH);
    term = 96'(1) << 32;
    sum  = term;
    for (k = 1; k <= 20; k++) begin
      term = ((term * x) >> 32) / 96'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return TabW'((sum + 96'd32768) >> 16);
  endfunction

  logic [TabW-1:0] lut [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_lut
    localparam logic [TabW-1:0] Entry = exp2_entry(gi);
    assign lut[gi] = Entry;
  end

  logic [1:0] vld_q;
  logic [1:0] rdy;

  logic [FracW-1:0] frac;
  logic [IdxW-1:0]  idx;
  logic [ShW-1:0]   sh_d, sh_q;
  logic [TabW-1:0]  tab_d, tab_q;
  logic [TabW-1:0]  shifted;
  logic [HeatW-1:0] heat_d, heat_q;

  assign rdy[1]     = !vld_q[1] || out_ready_i;
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign frac  = exp2_arg_i[FracW-1:0];
  assign sh_d  = exp2_arg_i[ghp_pkg::ExpW-1:FracW];
  assign idx   = IdxW'((32'(frac) * 32'(EXP_TABLE_DEPTH)) >> FracW);
  assign tab_d = lut[idx];

  assign shifted = tab_q >> sh_q;

  always_comb begin
    if (sh_q >= ShW'(16)) begin
      heat_d = '0;
    end else if (shifted > TabW'(ghp_pkg::HeatMax)) begin
      heat_d = ghp_pkg::HeatMax;
    end else begin
      heat_d = HeatW'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      sh_q  <= sh_d;
      tab_q <= tab_d;
    end
    if (rdy[1] && vld_q[0]) begin
      heat_q <= heat_d;
    end
  end

  assign out_valid_o  = vld_q[1];
  assign heat_value_o = heat_q;

endmodule

FILE: hw/rtl/gaussian_heatmap_pixel_unit.sv
`timescale 1ns / 1ps
// pipeline: 8 register stages from the edge that accepts the input transfer
//   to the output register
// throughput: one pixel per cycle unless stalled, set by the per-stage
//   valid bits; a stalled output holds only the stages that are occupied
// reset: clears all valid bits and loads grid_reciprocal = 1024 and
//   gauss_coefficient = 51200; the exp2 table is constant logic
// ----------------------------------------------------------------------------
// gaussian_heatmap_pixel_unit
// Gaussian heat value of one heat-map pixel for one joint position per
// transfer, with configuration registers for grid reciprocal and coefficient.
// ----------------------------------------------------------------------------
module gaussian_heatmap_pixel_unit #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ghp_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [ghp_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_row[7:0], pixel_col[15:8], joint_x[32:16], joint_y[49:33], zero[55:50]
  input  logic [ghp_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // heat_value[15:0]
  output logic [ghp_pkg::OutTdataW-1:0]     m_axis_tdata
);

  logic [ghp_pkg::GridW-1:0] grid_recip_q;
  logic [ghp_pkg::CoefW-1:0] gauss_coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_recip_q <= ghp_pkg::GridRecipRst;
      gauss_coef_q <= ghp_pkg::GaussCoefRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == ghp_pkg::CfgGridRecip) begin
        grid_recip_q <= cfg_wdata_i[ghp_pkg::GridW-1:0];
      end
      if (cfg_addr_i == ghp_pkg::CfgGaussCoef) begin
        gauss_coef_q <= cfg_wdata_i[ghp_pkg::CoefW-1:0];
      end
    end
  end

  logic                         dist_valid, dist_ready;
  logic [ghp_pkg::SqW-1:0]      dx_sq, dy_sq;
  logic                         arg_valid, arg_ready;
  logic [ghp_pkg::ExpW-1:0]     exp2_arg;

  ghp_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .pixel_row_i  (s_axis_tdata[7:0]),
    .pixel_col_i  (s_axis_tdata[15:8]),
    .joint_x_i    (s_axis_tdata[32:16]),
    .joint_y_i    (s_axis_tdata[49:33]),
    .grid_recip_i (grid_recip_q),
    .out_valid_o  (dist_valid),
    .out_ready_i  (dist_ready),
    .dx_sq_o      (dx_sq),
    .dy_sq_o      (dy_sq)
  );

  ghp_arg u_arg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (dist_valid),
    .in_ready_o   (dist_ready),
    .dx_sq_i      (dx_sq),
    .dy_sq_i      (dy_sq),
    .gauss_coef_i (gauss_coef_q),
    .out_valid_o  (arg_valid),
    .out_ready_i  (arg_ready),
    .exp2_arg_o   (exp2_arg)
  );

  ghp_exp2 #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp2 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (arg_valid),
    .in_ready_o   (arg_ready),
    .exp2_arg_i   (exp2_arg),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .heat_value_o (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/ghp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghp_checker
// Port-level checks of the Gaussian heat-map pixel unit: output hold under
// stall, reset behavior, item accounting and acceptance when empty.
// ----------------------------------------------------------------------------
module ghp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ghp_pkg::OutTdataW-1:0]  m_axis_tdata
);

  localparam int unsigned CntW = $clog2(ghp_pkg::PipeDepth + 1);

  logic            in_xfer, out_xfer;
  logic [CntW-1:0] cnt_d, cnt_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign cnt_d    = cnt_q + CntW'(in_xfer) - CntW'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result without a pending input transfer");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ghp_pkg::PipeDepth))
    else $error("more items in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> s_axis_tready)
    else $error("empty pipeline refuses input");

endmodule

bind gaussian_heatmap_pixel_unit ghp_checker u_ghp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
